// ===== rtl/core/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types, register map and saturating arithmetic for the conserved
// block counter.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

  localparam int SUM_W    = 26;
  localparam int FRAC_W   = 9;
  localparam int COUNT_W  = 13;
  localparam int WEIGHT_W = 16;
  localparam int SYM_W    = 3;
  localparam int SCALED_W = SUM_W + FRAC_W;
  localparam int NUM_BASES = 4;
  localparam int HITS_W   = 3;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_INDEX_W = 3;

  localparam logic [REG_INDEX_W-1:0] REG_TOTAL_WEIGHT          = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_GAP_FRACTION_LIMIT    = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_CONSERVATION_FRACTION = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_MIN_SUPPORT           = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_MIN_BLOCK_LENGTH      = 3'd4;

  localparam logic [SUM_W-1:0]   RST_TOTAL_WEIGHT          = 26'd256;
  localparam logic [FRAC_W-1:0]  RST_GAP_FRACTION_LIMIT    = 9'd154;
  localparam logic [FRAC_W-1:0]  RST_CONSERVATION_FRACTION = 9'd179;
  localparam logic [SUM_W-1:0]   RST_MIN_SUPPORT           = 26'd768;
  localparam logic [COUNT_W-1:0] RST_MIN_BLOCK_LENGTH      = 13'd4;

  localparam logic [SYM_W-1:0] SYM_GAP = 3'd4;

  typedef struct packed {
    logic [SUM_W-1:0]   total_weight;
    logic [FRAC_W-1:0]  gap_fraction_limit;
    logic [FRAC_W-1:0]  conservation_fraction;
    logic [SUM_W-1:0]   min_support;
    logic [COUNT_W-1:0] min_block_length;
  } cfg_regs_t;

  // Thresholds pre-multiplied by the total weight.
  typedef struct packed {
    logic [SCALED_W-1:0] gap_scaled;
    logic [SCALED_W-1:0] cons_scaled;
  } cfg_scaled_t;

  // Verdict on one finished column.
  typedef struct packed {
    logic              skip;
    logic [HITS_W-1:0] hits;
    logic              aln_end;
  } col_class_t;

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                               input logic [WEIGHT_W-1:0] w);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W-WEIGHT_W+1){1'b0}}, w};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cbc_cfg.sv =====
// ----------------------------------------------------------------------------
// cbc_cfg
// APB register file plus registered threshold products.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cbc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cbc_pkg::DATA_W-1:0] pwdata,
  output logic      [cbc_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output cbc_pkg::cfg_regs_t              regs,
  output cbc_pkg::cfg_scaled_t            scaled
);
  import cbc_pkg::*;

  logic [REG_INDEX_W-1:0] index;
  logic                   wr_en;

  assign index  = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.total_weight          <= RST_TOTAL_WEIGHT;
      regs.gap_fraction_limit    <= RST_GAP_FRACTION_LIMIT;
      regs.conservation_fraction <= RST_CONSERVATION_FRACTION;
      regs.min_support           <= RST_MIN_SUPPORT;
      regs.min_block_length      <= RST_MIN_BLOCK_LENGTH;
    end else if (wr_en) begin
      unique case (index)
        REG_TOTAL_WEIGHT:          regs.total_weight          <= pwdata[SUM_W-1:0];
        REG_GAP_FRACTION_LIMIT:    regs.gap_fraction_limit    <= pwdata[FRAC_W-1:0];
        REG_CONSERVATION_FRACTION: regs.conservation_fraction <= pwdata[FRAC_W-1:0];
        REG_MIN_SUPPORT:           regs.min_support           <= pwdata[SUM_W-1:0];
        REG_MIN_BLOCK_LENGTH:      regs.min_block_length      <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_TOTAL_WEIGHT:
        prdata = {{(DATA_W-SUM_W){1'b0}}, regs.total_weight};
      REG_GAP_FRACTION_LIMIT:
        prdata = {{(DATA_W-FRAC_W){1'b0}}, regs.gap_fraction_limit};
      REG_CONSERVATION_FRACTION:
        prdata = {{(DATA_W-FRAC_W){1'b0}}, regs.conservation_fraction};
      REG_MIN_SUPPORT:
        prdata = {{(DATA_W-SUM_W){1'b0}}, regs.min_support};
      REG_MIN_BLOCK_LENGTH:
        prdata = {{(DATA_W-COUNT_W){1'b0}}, regs.min_block_length};
      default:
        prdata = '0;
    endcase
  end

  // User changes registers only while idle (unenforced), hiding product lag.
  always_ff @(posedge clk) begin
    scaled.gap_scaled  <= SCALED_W'(regs.gap_fraction_limit) * SCALED_W'(regs.total_weight);
    scaled.cons_scaled <= SCALED_W'(regs.conservation_fraction) * SCALED_W'(regs.total_weight);
  end

endmodule

`default_nettype wire

// ===== rtl/core/cbc_accum.sv =====
// ----------------------------------------------------------------------------
// cbc_accum
// Input register and per-column weight accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_accum (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        advance,
  input  wire logic                                        in_valid,
  input  wire logic [cbc_pkg::SYM_W-1:0]                   symbol,
  input  wire logic [cbc_pkg::WEIGHT_W-1:0]                weight,
  input  wire logic                                        column_end,
  input  wire logic                                        alignment_end,
  output logic                                             col_valid,
  output logic [cbc_pkg::NUM_BASES-1:0][cbc_pkg::SUM_W-1:0] col_base,
  output logic [cbc_pkg::SUM_W-1:0]                        col_gap,
  output logic                                             col_aln
);
  import cbc_pkg::*;

  logic                    s1_valid;
  logic [SYM_W-1:0]        s1_symbol;
  logic [WEIGHT_W-1:0]     s1_weight;
  logic                    s1_col_end;
  logic                    s1_aln_end;

  logic [NUM_BASES-1:0][SUM_W-1:0] base_sum;
  logic [SUM_W-1:0]                gap_sum;
  logic [NUM_BASES-1:0][SUM_W-1:0] base_sum_next;
  logic [SUM_W-1:0]                gap_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_symbol  <= symbol;
      s1_weight  <= weight;
      s1_col_end <= column_end || alignment_end;
      s1_aln_end <= alignment_end;
    end
  end

  always_comb begin
    for (int b = 0; b < NUM_BASES; b++) begin
      base_sum_next[b] = (s1_symbol == SYM_W'(b)) ? sat_sum(base_sum[b], s1_weight)
                                                  : base_sum[b];
    end
    gap_sum_next = (s1_symbol == SYM_GAP) ? sat_sum(gap_sum, s1_weight) : gap_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_sum  <= '0;
      gap_sum   <= '0;
      col_valid <= 1'b0;
    end else if (advance) begin
      col_valid <= s1_valid && s1_col_end;
      if (s1_valid) begin
        if (s1_col_end) begin
          base_sum <= '0;
          gap_sum  <= '0;
        end else begin
          base_sum <= base_sum_next;
          gap_sum  <= gap_sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      col_base <= base_sum_next;
      col_gap  <= gap_sum_next;
      col_aln  <= s1_aln_end;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cbc_classify.sv =====
// ----------------------------------------------------------------------------
// cbc_classify
// Gap-skip and conserved-base tests on a finished column.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_classify (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         advance,
  input  wire logic                                         col_valid,
  input  wire logic [cbc_pkg::NUM_BASES-1:0][cbc_pkg::SUM_W-1:0] col_base,
  input  wire logic [cbc_pkg::SUM_W-1:0]                    col_gap,
  input  wire logic                                         col_aln,
  input  wire cbc_pkg::cfg_regs_t                           regs,
  input  wire cbc_pkg::cfg_scaled_t                         scaled,
  output logic                                              cls_valid,
  output cbc_pkg::col_class_t                               cls
);
  import cbc_pkg::*;

  logic [NUM_BASES-1:0] qualify;
  logic [HITS_W-1:0]    hits;
  logic                 skip;

  always_comb begin
    hits = '0;
    for (int b = 0; b < NUM_BASES; b++) begin
      qualify[b] = ({1'b0, col_base[b], 8'h00} > scaled.cons_scaled) &&
                   (col_base[b] >= regs.min_support);
      hits = hits + HITS_W'(qualify[b]);
    end
    skip = {1'b0, col_gap, 8'h00} > scaled.gap_scaled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (advance) begin
      cls_valid <= col_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cls.skip    <= skip;
      cls.hits    <= hits;
      cls.aln_end <= col_aln;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cbc_tally.sv =====
// ----------------------------------------------------------------------------
// cbc_tally
// Run length and block total bookkeeping, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_tally (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,
  input  wire logic                        cls_valid,
  input  wire cbc_pkg::col_class_t         cls,
  input  wire logic [cbc_pkg::COUNT_W-1:0] min_block_length,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic [cbc_pkg::COUNT_W-1:0]      conserved_total,
  output logic                             hold
);
  import cbc_pkg::*;

  logic [COUNT_W-1:0] run_length;
  logic [COUNT_W-1:0] counted_total;
  logic [COUNT_W-1:0] run_grown;
  logic               do_close;
  logic [COUNT_W-1:0] total_next;

  // At most one close per column: a column with no conserved base leaves the
  // run unchanged before the close, so closing again at alignment end is moot.
  always_comb begin
    run_grown  = (!cls.skip && cls.hits != '0)
               ? sat_count(run_length, COUNT_W'(cls.hits)) : run_length;
    do_close   = cls.aln_end || (!cls.skip && cls.hits == '0);
    total_next = (do_close && run_grown >= min_block_length)
               ? sat_count(counted_total, run_grown) : counted_total;
  end

  // Hold the pipe only when a result is ready and the output is still occupied.
  assign hold = out_valid && out_stall && cls_valid && cls.aln_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length    <= '0;
      counted_total <= '0;
    end else if (advance && cls_valid) begin
      if (cls.aln_end) begin
        run_length    <= '0;
        counted_total <= '0;
      end else begin
        run_length    <= do_close ? '0 : run_grown;
        counted_total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && cls_valid && cls.aln_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cls_valid && cls.aln_end) begin
      conserved_total <= total_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/conserved_block_counter.sv =====
// ----------------------------------------------------------------------------
// conserved_block_counter
// Counts the length of conserved blocks in a weighted nucleotide alignment.
// ----------------------------------------------------------------------------
// Stream the alignment column by column, one symbol beat per cycle; the block
// takes a beat every cycle in which in_stall is low. An alignment_end beat
// reaches the conserved_total beat through the input, accumulate, classify
// and tally registers. The rate is set by the weight accumulators, which add
// one Q8.8 weight per cycle while the pipe is not stalled. The input only
// stalls when a total is ready while the previous total is still waiting on
// the output; each such stall freezes every beat in flight. Behind the input
// register sit three stages: accumulate the per-column base and gap weights,
// classify the finished column (gap skip, conserved bases against thresholds
// pre-multiplied by total_weight), and update the run length and block total.
// Weight sums saturate at 2^26-1 and counts at 8191. Write registers over APB
// only while the block is idle; register i sits at byte address 4*i.
// ----------------------------------------------------------------------------
`default_nettype none

module conserved_block_counter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // symbol beats
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [cbc_pkg::SYM_W-1:0]    symbol,
  input  wire logic [cbc_pkg::WEIGHT_W-1:0] weight,
  input  wire logic                        column_end,
  input  wire logic                        alignment_end,
  // result beats
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [cbc_pkg::COUNT_W-1:0]      conserved_total,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cbc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [cbc_pkg::DATA_W-1:0]  pwdata,
  output logic      [cbc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import cbc_pkg::*;

  cfg_regs_t   regs;
  cfg_scaled_t scaled;

  logic                            col_valid;
  logic [NUM_BASES-1:0][SUM_W-1:0] col_base;
  logic [SUM_W-1:0]                col_gap;
  logic                            col_aln;

  logic       cls_valid;
  col_class_t cls;

  logic hold;
  logic advance;

  // The whole pipe moves together; it freezes only behind a blocked result.
  assign advance  = !hold;
  assign in_stall = hold;

  cbc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs),
    .scaled  (scaled)
  );

  cbc_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (in_valid),
    .symbol        (symbol),
    .weight        (weight),
    .column_end    (column_end),
    .alignment_end (alignment_end),
    .col_valid     (col_valid),
    .col_base      (col_base),
    .col_gap       (col_gap),
    .col_aln       (col_aln)
  );

  cbc_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .col_valid (col_valid),
    .col_base  (col_base),
    .col_gap   (col_gap),
    .col_aln   (col_aln),
    .regs      (regs),
    .scaled    (scaled),
    .cls_valid (cls_valid),
    .cls       (cls)
  );

  cbc_tally u_tally (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .cls_valid        (cls_valid),
    .cls              (cls),
    .min_block_length (regs.min_block_length),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .conserved_total  (conserved_total),
    .hold             (hold)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cbc_checker.sv =====
// ----------------------------------------------------------------------------
// cbc_checker
// Port-level checks for the conserved block counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        alignment_end,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [cbc_pkg::COUNT_W-1:0] conserved_total
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(conserved_total))
    else $error("result beat changed while stalled");

  // Input back-pressure only comes from a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // With no stall on the way, a fresh result follows an accepted alignment
  // end through the input, accumulate, classify and tally registers.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !$past(in_stall, 1) && !$past(in_stall, 2) &&
    !$past(in_stall, 3) && !$past(in_stall, 4)
    |-> $past(in_valid && alignment_end, 4))
    else $error("result without matching alignment end");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind conserved_block_counter cbc_checker u_cbc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .alignment_end   (alignment_end),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .conserved_total (conserved_total)
);

`default_nettype wire
